// ===== sv/rsbc_pkg.sv =====
// rsbc_pkg: shared constants for the remote switch bypass controller
// action codes, configuration register indexes and reset values
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsbc_pkg;

  localparam int TICK_COUNT_WIDTH_DEF = 16;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int ACTION_W    = 3;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_BUTTON    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_MSG_ON    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_MSG_OFF   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_MSG_OTHER = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISCHARGE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOGGLE_ON_FALL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOGGLE_ON_RISE = 2'd3;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] ACK_TIMEOUT_RST = 16'd1500;
  localparam logic [CFG_DATA_W-1:0] DISCHARGE_RST   = 16'd1000;
  localparam logic                  TOGGLE_FALL_RST = 1'b1;
  localparam logic                  TOGGLE_RISE_RST = 1'b0;

endpackage

`default_nettype wire

// ===== sv/remote_switch_bypass_controller.sv =====
// remote_switch_bypass_controller: lamp toggle, acknowledgement timer and relay bypass
// depends on rsbc_pkg
//
// Usage:
//   Input words (in_action, in_button_level) arrive on a valid/ready channel:
//   ticks, button changes and lamp state messages. Every accepted word yields
//   exactly one result word on the out_ channel: relay drive, lamp state,
//   command request with its value, bypass flag and timeout flag.
//   The result of a word accepted at one edge is valid right after that edge.
//   Throughput is one word per cycle while out_ready is high; the next state
//   is computed from the state registers and the incoming word in one pass.
//   in_ready is high whenever the result register is empty or is being
//   taken in the same cycle, so a stalled receiver holds the result and
//   stops input after one word.
//   Configuration (cfg_we, cfg_index, cfg_wdata) is to be written by the user
//   only while the block is idle; the block itself does not enforce this.
//   Synchronous reset (rst_n low) turns the lamp off, opens the relay, clears
//   the wait and discharge counters, empties the result register and loads
//   the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module remote_switch_bypass_controller #(
  parameter int TICK_COUNT_WIDTH = rsbc_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rsbc_pkg::ACTION_W-1:0]    in_action,
  input  wire logic                             in_button_level,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_relay_drive,
  output logic                                  out_lamp_state,
  output logic                                  out_send_command,
  output logic                                  out_command_value,
  output logic                                  out_bypass_active,
  output logic                                  out_timeout_event,
  input  wire logic                             cfg_we,
  input  wire logic [rsbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rsbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int W     = TICK_COUNT_WIDTH;
  localparam int CMP_W = (W > rsbc_pkg::CFG_DATA_W) ? W : rsbc_pkg::CFG_DATA_W;
  localparam logic [W-1:0] CNT_MAX = '1;

  // configuration
  logic [rsbc_pkg::CFG_DATA_W-1:0] ack_timeout_r;
  logic [rsbc_pkg::CFG_DATA_W-1:0] discharge_ticks_r;
  logic                            toggle_on_fall_r;
  logic                            toggle_on_rise_r;

  // state
  logic         lamp_on_r, lamp_on_nxt;
  logic         relay_closed_r, relay_closed_nxt;
  logic         command_failed_r, command_failed_nxt;
  logic         awaiting_ack_r, awaiting_ack_nxt;
  logic [W-1:0] wait_count_r, wait_count_nxt;
  logic [W-1:0] discharge_count_r, discharge_count_nxt;

  logic         send_nxt;
  logic         timeout_nxt;
  logic         out_valid_r;
  logic         in_accept;
  logic [W-1:0] discharge_load;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r     <= rsbc_pkg::ACK_TIMEOUT_RST;
      discharge_ticks_r <= rsbc_pkg::DISCHARGE_RST;
      toggle_on_fall_r  <= rsbc_pkg::TOGGLE_FALL_RST;
      toggle_on_rise_r  <= rsbc_pkg::TOGGLE_RISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsbc_pkg::REG_ACK_TIMEOUT:    ack_timeout_r     <= cfg_wdata;
        rsbc_pkg::REG_DISCHARGE:      discharge_ticks_r <= cfg_wdata;
        rsbc_pkg::REG_TOGGLE_ON_FALL: toggle_on_fall_r  <= cfg_wdata[0];
        rsbc_pkg::REG_TOGGLE_ON_RISE: toggle_on_rise_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // discharge interval saturated to the counter width
  assign discharge_load = (CMP_W'(discharge_ticks_r) > CMP_W'(CNT_MAX)) ?
                          CNT_MAX : W'(discharge_ticks_r);

  always_comb begin
    lamp_on_nxt         = lamp_on_r;
    relay_closed_nxt    = relay_closed_r;
    command_failed_nxt  = command_failed_r;
    awaiting_ack_nxt    = awaiting_ack_r;
    wait_count_nxt      = wait_count_r;
    discharge_count_nxt = discharge_count_r;
    send_nxt            = 1'b0;
    timeout_nxt         = 1'b0;
    unique case (in_action)
      rsbc_pkg::ACT_TICK: begin
        if (discharge_count_r != '0) begin
          discharge_count_nxt = discharge_count_r - W'(1);
          if (discharge_count_nxt == '0 && command_failed_r) begin
            relay_closed_nxt = lamp_on_r;
          end
        end
        if (awaiting_ack_r) begin
          if (CMP_W'(wait_count_r) >= CMP_W'(ack_timeout_r) || wait_count_r == CNT_MAX) begin
            awaiting_ack_nxt   = 1'b0;
            wait_count_nxt     = '0;
            command_failed_nxt = 1'b1;
            timeout_nxt        = 1'b1;
            if (lamp_on_r && relay_closed_nxt) begin
              relay_closed_nxt    = 1'b0;
              discharge_count_nxt = discharge_load;
            end
          end else begin
            wait_count_nxt = wait_count_r + W'(1);
          end
          if (command_failed_nxt && discharge_count_nxt == '0) begin
            relay_closed_nxt = lamp_on_r;
          end
        end
      end
      rsbc_pkg::ACT_BUTTON: begin
        if ((!in_button_level && toggle_on_fall_r) || (in_button_level && toggle_on_rise_r)) begin
          lamp_on_nxt      = !lamp_on_r;
          send_nxt         = 1'b1;
          awaiting_ack_nxt = 1'b1;
          wait_count_nxt   = '0;
        end
      end
      rsbc_pkg::ACT_MSG_ON, rsbc_pkg::ACT_MSG_OFF, rsbc_pkg::ACT_MSG_OTHER: begin
        if (command_failed_r) begin
          send_nxt           = 1'b1;
          awaiting_ack_nxt   = 1'b1;
          wait_count_nxt     = '0;
          command_failed_nxt = 1'b0;
        end else if (in_action == rsbc_pkg::ACT_MSG_ON) begin
          lamp_on_nxt         = 1'b1;
          awaiting_ack_nxt    = 1'b0;
          wait_count_nxt      = '0;
          relay_closed_nxt    = 1'b1;
          discharge_count_nxt = '0;
        end else if (in_action == rsbc_pkg::ACT_MSG_OFF) begin
          lamp_on_nxt      = 1'b0;
          awaiting_ack_nxt = 1'b0;
          wait_count_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_on_r         <= 1'b0;
      relay_closed_r    <= 1'b0;
      command_failed_r  <= 1'b0;
      awaiting_ack_r    <= 1'b0;
      wait_count_r      <= '0;
      discharge_count_r <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_accept) begin
        lamp_on_r         <= lamp_on_nxt;
        relay_closed_r    <= relay_closed_nxt;
        command_failed_r  <= command_failed_nxt;
        awaiting_ack_r    <= awaiting_ack_nxt;
        wait_count_r      <= wait_count_nxt;
        discharge_count_r <= discharge_count_nxt;
        out_valid_r       <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_relay_drive   <= relay_closed_nxt;
      out_lamp_state    <= lamp_on_nxt;
      out_send_command  <= send_nxt;
      out_command_value <= send_nxt && lamp_on_nxt;
      out_bypass_active <= command_failed_nxt;
      out_timeout_event <= timeout_nxt;
    end
  end

  a_discharge_relay_open: assert property (@(posedge clk) disable iff (!rst_n)
    discharge_count_r != '0 |-> !relay_closed_r)
    else $error("relay closed while discharge is running");

  a_idle_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_ack_r |-> wait_count_r == '0)
    else $error("wait counter nonzero while not waiting");

  a_timeout_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_timeout_event |-> out_bypass_active && !out_send_command)
    else $error("timeout word without bypass");

  a_command_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_command_value |-> out_send_command && out_lamp_state)
    else $error("command value without command");

endmodule

`default_nettype wire
